[design/sgts_pkg.sv]
// ----------------------------------------------------------------------------
// sgts_pkg
// Shared types and constants for the staggered-grid trilinear sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package sgts_pkg;

  localparam int GRID_SIZE_DEF = 32;
  // index and address widths sized for the largest grid (128 cells per axis)
  localparam int IDX_W  = 8;
  localparam int ADDR_W = 22;
  localparam int FRAC_W = 16;
  localparam int VAL_W  = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] COMP_U   = 2'd0;
  localparam logic [1:0] COMP_V   = 2'd1;
  localparam logic [1:0] COMP_W   = 2'd2;
  localparam logic [1:0] COMP_BAD = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  idx0;
    logic [IDX_W-1:0]  idx1;
    logic [FRAC_W-1:0] frac;
  } sgts_axis_t;

  typedef struct packed {
    logic                    is_query;
    logic [1:0]              comp;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] val;
    sgts_axis_t [2:0][2:0]   ax;     // [component][axis]
  } sgts_cmd_t;

endpackage

`default_nettype wire

[design/sgts_ram.sv]
// ----------------------------------------------------------------------------
// sgts_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/sgts_front.sv]
// ----------------------------------------------------------------------------
// sgts_front
// Accepts requests, drops writes outside a store, forms write addresses and
// splits query positions into clamped neighbour indices and fractions.
// ----------------------------------------------------------------------------
`default_nettype none

module sgts_front #(
  parameter int GRID_SIZE = sgts_pkg::GRID_SIZE_DEF
) (
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_op,
  input  wire logic [1:0]         in_component,
  input  wire logic [5:0]         in_face_x,
  input  wire logic [5:0]         in_face_y,
  input  wire logic [5:0]         in_face_z,
  input  wire logic signed [15:0] in_sample_value,
  input  wire logic [15:0]        in_pos_x,
  input  wire logic [15:0]        in_pos_y,
  input  wire logic [15:0]        in_pos_z,
  output logic                    q_push,
  input  wire logic               q_full,
  output sgts_pkg::sgts_cmd_t     q_data
);

  localparam int GW    = $clog2(GRID_SIZE + 1);
  localparam int PRW   = 16 + GW;
  localparam int CW    = PRW + 1;
  localparam int CELLW = CW - 16;

  function automatic logic [sgts_pkg::IDX_W-1:0] clamp_idx(
    input logic signed [CELLW-1:0] v, input logic [sgts_pkg::IDX_W-1:0] lim);
    int vi;
    vi = int'(v);
    if (vi < 0) return '0;
    else if (vi > int'(lim)) return lim;
    else return sgts_pkg::IDX_W'(vi);
  endfunction

  logic [15:0]              pos [3];
  logic signed [CW-1:0]     cpos [2][3];   // [shifted][axis]
  logic signed [CELLW-1:0]  cell_v;
  logic [sgts_pkg::IDX_W-1:0] lim;
  logic                     sh;
  logic                     wr_ok;
  logic [sgts_pkg::IDX_W-1:0] wlim [3];
  int                       lin;
  int                       xd, yd;

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;

  always_comb begin
    q_data          = '0;
    q_data.is_query = (in_op == sgts_pkg::OP_QUERY);
    q_data.comp     = in_component;
    q_data.val      = in_sample_value;
    for (int a = 0; a < 3; a++) begin
      cpos[0][a] = $signed({1'b0, PRW'(pos[a]) * PRW'(GRID_SIZE)});
      cpos[1][a] = cpos[0][a] - CW'(32768);   // half a cell back
    end
    cell_v = '0;
    lim    = '0;
    sh     = 1'b0;
    for (int c = 0; c < 3; c++) begin
      for (int a = 0; a < 3; a++) begin
        sh     = (a != c);
        lim    = (a == c) ? sgts_pkg::IDX_W'(GRID_SIZE) : sgts_pkg::IDX_W'(GRID_SIZE - 1);
        cell_v = cpos[sh][a][CW-1:16];
        q_data.ax[c][a].idx0 = clamp_idx(cell_v, lim);
        q_data.ax[c][a].idx1 = clamp_idx(cell_v + CELLW'(1), lim);
        q_data.ax[c][a].frac = cpos[sh][a][15:0];
      end
    end
    // write extent per axis for the addressed store
    for (int a = 0; a < 3; a++) begin
      wlim[a] = (int'(in_component) == a) ? sgts_pkg::IDX_W'(GRID_SIZE)
                                          : sgts_pkg::IDX_W'(GRID_SIZE - 1);
    end
    wr_ok = (in_component != sgts_pkg::COMP_BAD) &&
            (int'(in_face_x) <= int'(wlim[0])) &&
            (int'(in_face_y) <= int'(wlim[1])) &&
            (int'(in_face_z) <= int'(wlim[2]));
    xd  = (in_component == sgts_pkg::COMP_U) ? GRID_SIZE + 1 : GRID_SIZE;
    yd  = (in_component == sgts_pkg::COMP_V) ? GRID_SIZE + 1 : GRID_SIZE;
    lin = int'(in_face_x) + xd * (int'(in_face_y) + yd * int'(in_face_z));
    q_data.wr_addr = sgts_pkg::ADDR_W'(lin);
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full && (q_data.is_query || wr_ok);

endmodule

`default_nettype wire

[design/sgts_queue.sv]
// ----------------------------------------------------------------------------
// sgts_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module sgts_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire sgts_pkg::sgts_cmd_t push_data,
  output logic                     full,
  input  wire logic                pop,
  output logic                     empty,
  output sgts_pkg::sgts_cmd_t      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  sgts_pkg::sgts_cmd_t slot_r [DEPTH];
  logic [PW-1:0]  wptr_r, rptr_r;
  logic [CNW-1:0] count_r;
  logic           do_push, do_pop;

  assign full     = (count_r == CNW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      count_r <= count_r + CNW'(do_push) - CNW'(do_pop);
    end
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[design/sgts_back.sv]
// ----------------------------------------------------------------------------
// sgts_back
// Carries out writes into the three face stores and walks the eight corners
// of a query, weighting and summing all three components in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module sgts_back #(
  parameter int GRID_SIZE = sgts_pkg::GRID_SIZE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire sgts_pkg::sgts_cmd_t q_data,
  output logic                     q_pop,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic signed [15:0]       out_vel_u,
  output logic signed [15:0]       out_vel_v,
  output logic signed [15:0]       out_vel_w
);

  localparam int DEPTH  = (GRID_SIZE + 1) * GRID_SIZE * GRID_SIZE;
  localparam int AW     = $clog2(DEPTH);
  localparam int WXY_W  = 34;
  localparam int WXYZ_W = 50;
  localparam int PROD_W = 16 + WXYZ_W + 1;
  localparam int ACC_W  = PROD_W + 3;

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_DRAIN, B_DONE} bstate_t;

  bstate_t             state_r;
  logic [2:0]          corner_r;
  logic                v1_r, v2_r, v3_r;
  sgts_pkg::sgts_cmd_t cmd_r;
  logic                out_valid_r;
  logic                out_free;

  function automatic logic [16:0] wsel(input logic [15:0] f, input logic b);
    return b ? {1'b0, f} : (17'h10000 - {1'b0, f});
  endfunction

  assign out_free = !out_valid_r || out_pop;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  for (genvar c = 0; c < 3; c++) begin : g_comp
    localparam int XD = (c == 0) ? GRID_SIZE + 1 : GRID_SIZE;
    localparam int YD = (c == 1) ? GRID_SIZE + 1 : GRID_SIZE;
    int                       ix, iy, iz;
    logic [AW-1:0]            ram_addr;
    logic                     ram_we;
    logic [15:0]              ram_rd;
    logic [16:0]              wt [3];
    logic [WXY_W-1:0]         wxy_r;
    logic [16:0]              wz_r;
    logic [WXYZ_W-1:0]        wxyz_r;
    logic signed [15:0]       rd_r;
    logic signed [PROD_W-1:0] prod_r;
    logic signed [ACC_W-1:0]  acc_r;
    logic signed [ACC_W-1:0]  rsum;
    logic signed [ACC_W-49:0] rq;
    logic signed [15:0]       rsat;
    logic signed [15:0]       res_r;

    always_comb begin
      ix = int'(corner_r[0] ? cmd_r.ax[c][0].idx1 : cmd_r.ax[c][0].idx0);
      iy = int'(corner_r[1] ? cmd_r.ax[c][1].idx1 : cmd_r.ax[c][1].idx0);
      iz = int'(corner_r[2] ? cmd_r.ax[c][2].idx1 : cmd_r.ax[c][2].idx0);
      for (int a = 0; a < 3; a++) begin
        wt[a] = wsel(cmd_r.ax[c][a].frac, corner_r[a]);
      end
      if (state_r == B_IDLE) begin
        ram_addr = q_data.wr_addr[AW-1:0];
      end else begin
        ram_addr = AW'(ix + XD * (iy + YD * iz));
      end
      ram_we = q_pop && !q_data.is_query && (int'(q_data.comp) == c);
      // round to nearest, ties up, then saturate
      rsum = acc_r + (ACC_W'(1) <<< 47);
      rq   = rsum[ACC_W-1:48];
      if (rq > (ACC_W-48)'(32767)) rsat = 16'sh7fff;
      else if (rq < -(ACC_W-48)'(32768)) rsat = -16'sh8000;
      else rsat = rq[15:0];
    end

    sgts_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (q_data.val),
      .rdata (ram_rd)
    );

    always_ff @(posedge clk) begin
      wxy_r  <= WXY_W'(wt[0]) * WXY_W'(wt[1]);
      wz_r   <= wt[2];
      wxyz_r <= WXYZ_W'(wxy_r) * WXYZ_W'(wz_r);
      rd_r   <= $signed(ram_rd);
      prod_r <= PROD_W'(rd_r) * $signed({1'b0, wxyz_r});
      if (q_pop) begin
        acc_r <= '0;
      end else if (v3_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (state_r == B_DONE && out_free) begin
        res_r <= rsat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      corner_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= (state_r == B_RUN);
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (state_r == B_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          corner_r <= '0;
          if (q_pop && q_data.is_query) begin
            state_r <= B_RUN;
          end
        end
        B_RUN: begin
          corner_r <= corner_r + 3'd1;
          if (corner_r == 3'd7) begin
            state_r <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (!v1_r && !v2_r && !v3_r) begin
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
    if (q_pop) begin
      cmd_r <= q_data;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_vel_u = g_comp[0].res_r;
  assign out_vel_v = g_comp[1].res_r;
  assign out_vel_w = g_comp[2].res_r;

  // queue is only drained between queries
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN || state_r == B_DRAIN || state_r == B_DONE) |-> !q_pop)
    else $error("request taken while a query is in flight");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> $past(v2_r))
    else $error("accumulate stage without product stage");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN && corner_r == 3'd7) |=> state_r == B_DRAIN)
    else $error("corner walk did not end after eight corners");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DONE |-> (!v1_r && !v2_r && !v3_r))
    else $error("result formed before all corners summed");

endmodule

`default_nettype wire

[design/staggered_grid_trilinear_sample.sv]
// ----------------------------------------------------------------------------
// staggered_grid_trilinear_sample
// Staggered-grid velocity sampler: face stores for u, v, w filled by write
// requests, trilinear interpolation of all three components on queries.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------
//   input   | in_op .. in_pos_z                       | in_push / in_full
//   result  | out_vel_u, out_vel_v, out_vel_w         | out_pop / out_empty
//
// A write is carried out in the back part in the same cycle as it leaves the
// queue. A query holds the back part while it leaves the queue, for eight
// corner reads, one per cycle on the single port of each component store,
// while the read/weight/product/sum pipe drains and while the result loads.
// Reset (rst_n low, synchronous) clears the queue and control; the stores
// are not cleared. The back part stalls with a finished query while the
// result register is full; the front keeps filling the two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_grid_trilinear_sample #(
  parameter int GRID_SIZE = sgts_pkg::GRID_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_op,
  input  wire logic [1:0]         in_component,
  input  wire logic [5:0]         in_face_x,
  input  wire logic [5:0]         in_face_y,
  input  wire logic [5:0]         in_face_z,
  input  wire logic signed [15:0] in_sample_value,
  input  wire logic [15:0]        in_pos_x,
  input  wire logic [15:0]        in_pos_y,
  input  wire logic [15:0]        in_pos_z,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [15:0]      out_vel_u,
  output logic signed [15:0]      out_vel_v,
  output logic signed [15:0]      out_vel_w
);

  logic                q_push, q_full, q_pop, q_empty;
  sgts_pkg::sgts_cmd_t q_wdata, q_rdata;

  sgts_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_component    (in_component),
    .in_face_x       (in_face_x),
    .in_face_y       (in_face_y),
    .in_face_z       (in_face_z),
    .in_sample_value (in_sample_value),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .q_push          (q_push),
    .q_full          (q_full),
    .q_data          (q_wdata)
  );

  sgts_queue #(.DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  sgts_back #(.GRID_SIZE(GRID_SIZE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_vel_u (out_vel_u),
    .out_vel_v (out_vel_v),
    .out_vel_w (out_vel_w)
  );

endmodule

`default_nettype wire

[test/staggered_grid_trilinear_sample_tb.sv]
// ----------------------------------------------------------------------------
// staggered_grid_trilinear_sample_tb
// Self-checking bench for the staggered-grid sampler. Write requests fill the
// face stores; every query is preceded by writes to the corners it will read.
// A local interpolator predicts each result; a monitor compares every field.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_grid_trilinear_sample_tb;

  localparam int GRID  = sgts_pkg::GRID_SIZE_DEF;
  localparam int DEPTH = (GRID + 1) * GRID * GRID;
  localparam int NUM_ITEMS = 1350;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic        op;
    logic [1:0]  comp;
    logic [5:0]  fx, fy, fz;
    logic [15:0] val;
    logic [15:0] px, py, pz;
  } request_t;

  typedef struct {
    logic [15:0] u, v, w;
  } velocity_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_op = sgts_pkg::OP_WRITE;
  logic [1:0] in_component = sgts_pkg::COMP_U;
  logic [5:0] in_face_x = '0, in_face_y = '0, in_face_z = '0;
  logic signed [15:0] in_sample_value = '0;
  logic [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [15:0] out_vel_u, out_vel_v, out_vel_w;

  staggered_grid_trilinear_sample dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_t  pending[$];
  velocity_t expected_vel[$];
  shortint   face_store[3][DEPTH];
  bit        gen_written[3][DEPTH];
  int        next_req = 0;
  int        errors = 0;
  bit        gen_done = 1'b0;

  // corner address and weight of one component's trilinear stencil
  function automatic void stencil_corner(input int comp, input logic [15:0] px, py, pz,
                                         input int corner, output int lin, output longint wt);
    longint pv[3];
    longint c, cell_v, frac, idx[3], lim;
    int xd, yd;
    pv[0] = px; pv[1] = py; pv[2] = pz;
    wt = 1;
    for (int a = 0; a < 3; a++) begin
      c = pv[a] * GRID - ((a != comp) ? 32768 : 0);
      cell_v = c >>> 16;
      frac = c & 65535;
      lim = (a == comp) ? GRID : GRID - 1;
      idx[a] = cell_v + ((corner >> a) & 1);
      if (idx[a] < 0) idx[a] = 0;
      if (idx[a] > lim) idx[a] = lim;
      wt = wt * (((corner >> a) & 1) ? frac : 65536 - frac);
    end
    xd = (comp == 0) ? GRID + 1 : GRID;
    yd = (comp == 1) ? GRID + 1 : GRID;
    lin = int'(idx[0] + xd * (idx[1] + yd * idx[2]));
  endfunction

  function automatic logic [15:0] interpolate(input int comp, input logic [15:0] px, py, pz);
    longint acc, wt, r;
    int lin;
    acc = 0;
    for (int k = 0; k < 8; k++) begin
      stencil_corner(comp, px, py, pz, k, lin, wt);
      acc += longint'(face_store[comp][lin]) * wt;
    end
    r = (acc + (longint'(1) << 47)) >>> 48;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void apply_request(input request_t rq);
    int xd, yd, ci;
    velocity_t ev;
    if (rq.op == sgts_pkg::OP_QUERY) begin
      ev.u = interpolate(0, rq.px, rq.py, rq.pz);
      ev.v = interpolate(1, rq.px, rq.py, rq.pz);
      ev.w = interpolate(2, rq.px, rq.py, rq.pz);
      expected_vel.insert(expected_vel.size(), ev);
    end else if (rq.comp != sgts_pkg::COMP_BAD) begin
      ci = rq.comp;
      xd = (rq.comp == sgts_pkg::COMP_U) ? GRID + 1 : GRID;
      yd = (rq.comp == sgts_pkg::COMP_V) ? GRID + 1 : GRID;
      if (rq.fx < xd && rq.fy < yd &&
          rq.fz < ((rq.comp == sgts_pkg::COMP_W) ? GRID + 1 : GRID))
        face_store[ci][rq.fx + xd * (rq.fy + yd * rq.fz)] = shortint'(rq.val);
    end
  endfunction

  function automatic void add_write(input logic [1:0] comp, input int fx, fy, fz,
                                    input logic [15:0] val);
    request_t rq;
    int xd, yd;
    rq.op = sgts_pkg::OP_WRITE; rq.comp = comp;
    rq.fx = 6'(fx); rq.fy = 6'(fy); rq.fz = 6'(fz); rq.val = val;
    rq.px = 16'($urandom); rq.py = 16'($urandom); rq.pz = 16'($urandom);
    pending.insert(pending.size(), rq);
    xd = (comp == sgts_pkg::COMP_U) ? GRID + 1 : GRID;
    yd = (comp == sgts_pkg::COMP_V) ? GRID + 1 : GRID;
    if (comp != sgts_pkg::COMP_BAD && rq.fx < xd && rq.fy < yd &&
        rq.fz < ((comp == sgts_pkg::COMP_W) ? GRID + 1 : GRID))
      gen_written[comp][rq.fx + xd * (rq.fy + yd * rq.fz)] = 1'b1;
  endfunction

  // writes any corner still unset, then queues the query itself
  function automatic void add_query(input logic [15:0] px, py, pz);
    request_t rq;
    int lin, xd, yd;
    longint wt;
    for (int c = 0; c < 3; c++) begin
      xd = (c == 0) ? GRID + 1 : GRID;
      yd = (c == 1) ? GRID + 1 : GRID;
      for (int k = 0; k < 8; k++) begin
        stencil_corner(c, px, py, pz, k, lin, wt);
        if (!gen_written[c][lin])
          add_write(2'(c), lin % xd, (lin / xd) % yd, lin / (xd * yd), 16'($urandom));
      end
    end
    rq.op = sgts_pkg::OP_QUERY; rq.comp = 2'($urandom); rq.fx = 6'($urandom);
    rq.fy = 6'($urandom); rq.fz = 6'($urandom); rq.val = 16'($urandom);
    rq.px = px; rq.py = py; rq.pz = pz;
    pending.insert(pending.size(), rq);
  endfunction

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1, 2: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(61440, 65535));
    endcase
  endfunction

  // stimulus: directed corners of the value and position ranges, then random
  initial begin
    add_write(sgts_pkg::COMP_U, 0, 0, 0, 16'h8000);
    add_write(sgts_pkg::COMP_U, 1, 0, 0, 16'h7fff);
    add_write(sgts_pkg::COMP_U, 32, 31, 31, 16'h7fff);
    add_write(sgts_pkg::COMP_W, 31, 31, 32, 16'h8000);
    add_write(sgts_pkg::COMP_V, 32, 0, 0, 16'h1234);   // outside v extent, ignored
    add_write(sgts_pkg::COMP_W, 0, 0, 33, 16'h4321);   // outside w extent, ignored
    add_write(sgts_pkg::COMP_BAD, 0, 0, 0, 16'h5555);  // bad component, ignored
    add_write(sgts_pkg::COMP_U, 63, 63, 63, 16'haaaa); // ignored
    add_query(16'h0000, 16'h0000, 16'h0000);
    add_query(16'hffff, 16'hffff, 16'hffff);
    add_query(16'h0400, 16'h0000, 16'h0000);
    add_query(16'h0800, 16'h0800, 16'h0800);
    add_query(16'hffff, 16'h0000, 16'hffff);
    while (pending.size() < NUM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        add_write(2'($urandom), int'($urandom_range(0, 63)), int'($urandom_range(0, 63)),
                  int'($urandom_range(0, 63)), 16'($urandom));
      else
        add_query(rand_pos(), rand_pos(), rand_pos());
    end
    gen_done = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (next_req == pending.size() && expected_vel.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_vel.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // sender: bursts of requests separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        apply_request(pending[next_req]);
        next_req++;
      end
      if (gap_left > 0 || !gen_done || next_req >= pending.size()) begin
        if (gap_left > 0) gap_left--;
        in_push <= 1'b0;
      end else begin
        in_push <= 1'b1;
        in_op <= pending[next_req].op;
        in_component <= pending[next_req].comp;
        in_face_x <= pending[next_req].fx;
        in_face_y <= pending[next_req].fy;
        in_face_z <= pending[next_req].fz;
        in_sample_value <= pending[next_req].val;
        in_pos_x <= pending[next_req].px;
        in_pos_y <= pending[next_req].py;
        in_pos_z <= pending[next_req].pz;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end
  end

  // receiver: stall pattern rotates through always-pop, random and sparse pops, plus one long hold-off
  int pop_phase = 0, hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_vel.size() == 0) begin
          $display("%0t: unexpected result u=%h v=%h w=%h", $time, out_vel_u, out_vel_v,
                   out_vel_w);
          errors++;
        end else begin
          if (out_vel_u !== expected_vel[0].u) begin
            $display("%0t: vel_u expected %h actual %h", $time, expected_vel[0].u, out_vel_u);
            errors++;
          end
          if (out_vel_v !== expected_vel[0].v) begin
            $display("%0t: vel_v expected %h actual %h", $time, expected_vel[0].v, out_vel_v);
            errors++;
          end
          if (out_vel_w !== expected_vel[0].w) begin
            $display("%0t: vel_w expected %h actual %h", $time, expected_vel[0].w, out_vel_w);
            errors++;
          end
          void'(expected_vel.pop_front());
        end
      end
      pop_phase++;
      if (!hold_done && next_req > 300) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        case ((pop_phase / 64) % 3)
          0: out_pop <= 1'b1;
          1: out_pop <= 1'($urandom_range(0, 1));
          default: out_pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no accepted request or result
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

`default_nettype wire
